// ===== sv/idf_pkg.sv =====
// ----------------------------------------------------------------------------
// idf_pkg
// Shared constants and types of the image deglitch filter.
// ----------------------------------------------------------------------------
package idf_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_PIXEL_BITS = 8;

    // configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 12;
    localparam int WIDTH_CFG_W = 11;
    localparam int THR_W       = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_GLITCH_THRESHOLD = 2'd2;

    localparam int RESET_WIDTH     = 30;
    localparam int RESET_HEIGHT    = 30;
    localparam int RESET_THRESHOLD = 1;

    // result fields
    localparam int OUT_ROW_W     = 12;
    localparam int OUT_COL_W     = 10;
    localparam int USER_W        = 2;
    localparam int USER_REPLACED = 0;
    localparam int USER_EOF      = 1;

    // four-neighborhood
    localparam int NB_COUNT = 4;

    localparam int MAX_RESULTS = 3;
    localparam int RES_CNT_W   = 2;

    typedef struct packed {
        logic has_out;    // row >= 1: pixel above is complete
        logic above_ok;   // row >= 2
        logic left_ok;    // col >= 1
        logic left2_ok;   // col >= 2
        logic right_ok;   // col is not the last column
        logic last_row;
        logic last_col;
    } pos_flags_t;

    typedef struct packed {
        logic                 load;
        logic [RES_CNT_W-1:0] cnt;
    } res_load_t;

endpackage

// ===== sv/idf_line_mem.sv =====
// ----------------------------------------------------------------------------
// idf_line_mem
// Column-indexed line store, two registered read ports, one write port,
// with write-to-read forwarding for a same-cycle access to one entry.
// ----------------------------------------------------------------------------
module idf_line_mem #(
    parameter int DEPTH  = idf_pkg::DEF_MAX_WIDTH,
    parameter int DATA_W = 2 * idf_pkg::DEF_PIXEL_BITS
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [DATA_W-1:0]        rd_data_a,
    output logic [DATA_W-1:0]        rd_data_b,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data
);
    import idf_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] q_a_reg;
    logic [DATA_W-1:0] q_b_reg;
    logic [DATA_W-1:0] fwd_data_reg;
    logic              fwd_a_reg;
    logic              fwd_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            q_a_reg      <= mem[rd_addr_a];
            q_b_reg      <= mem[rd_addr_b];
            fwd_data_reg <= wr_data;
        end
    end

    // the array returns old data on a colliding read; take the new word instead
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_a_reg <= 1'b0;
            fwd_b_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            fwd_a_reg <= wr_en && (wr_addr == rd_addr_a);
            fwd_b_reg <= wr_en && (wr_addr == rd_addr_b);
        end
    end

    assign rd_data_a = fwd_a_reg ? fwd_data_reg : q_a_reg;
    assign rd_data_b = fwd_b_reg ? fwd_data_reg : q_b_reg;

endmodule

// ===== sv/idf_judge.sv =====
// ----------------------------------------------------------------------------
// idf_judge
// Glitch decision for one pixel against up to four neighbors, with the
// rounded neighbor average as replacement.
// ----------------------------------------------------------------------------
module idf_judge #(
    parameter int PIXEL_BITS = idf_pkg::DEF_PIXEL_BITS
) (
    input  logic [PIXEL_BITS-1:0]            pix,
    input  logic [PIXEL_BITS-1:0]            nb [idf_pkg::NB_COUNT],
    input  logic [idf_pkg::NB_COUNT-1:0]     nb_en,
    input  logic [idf_pkg::THR_W-1:0]        thr,
    output logic [PIXEL_BITS-1:0]            pix_out,
    output logic                             replaced
);
    import idf_pkg::*;

    localparam int SW       = PIXEL_BITS + 2;
    localparam int CMPW     = (PIXEL_BITS > THR_W) ? PIXEL_BITS : THR_W;
    localparam int NB_CNT_W = $clog2(NB_COUNT + 1);
    // floor(v/3) = (v * ceil(2^S/3)) >> S, exact for v < 2^(S-1)
    localparam int DIV_S    = SW + 1;
    localparam int PW       = SW + DIV_S;
    localparam logic [DIV_S-1:0] DIV3_K = DIV_S'(((1 << DIV_S) + 2) / 3);

    logic [SW-1:0]         sum;
    logic [NB_CNT_W-1:0]   cnt;
    logic                  all_differ;
    logic [SW-1:0]         round1;
    logic [SW-1:0]         round2;
    logic [PW-1:0]         prod3;
    logic [PIXEL_BITS-1:0] avg;

    always_comb
    begin
        logic [PIXEL_BITS-1:0] diff;
        sum        = '0;
        cnt        = '0;
        all_differ = 1'b1;
        for (int i = 0; i < NB_COUNT; i++)
        begin
            diff = (pix > nb[i]) ? (pix - nb[i]) : (nb[i] - pix);
            if (nb_en[i])
            begin
                sum = sum + SW'(nb[i]);
                cnt = cnt + NB_CNT_W'(1);
                if (CMPW'(diff) <= CMPW'(thr))
                begin
                    all_differ = 1'b0;
                end
            end
        end
        if (cnt == '0)
        begin
            all_differ = 1'b0;
        end
    end

    // half-up rounding of sum / cnt
    assign round1 = sum + SW'(1);
    assign round2 = sum + SW'(2);
    assign prod3  = PW'(round1) * PW'(DIV3_K);

    always_comb
    begin
        case (cnt)
            NB_CNT_W'(1): avg = sum[PIXEL_BITS-1:0];
            NB_CNT_W'(2): avg = round1[PIXEL_BITS:1];
            NB_CNT_W'(3): avg = prod3[DIV_S +: PIXEL_BITS];
            NB_CNT_W'(4): avg = round2[PIXEL_BITS+1:2];
            default:      avg = pix;
        endcase
    end

    assign replaced = all_differ;
    assign pix_out  = all_differ ? avg : pix;

endmodule

// ===== sv/idf_out_queue.sv =====
// ----------------------------------------------------------------------------
// idf_out_queue
// Holds the results of one input and presents them one transfer at a time.
// ----------------------------------------------------------------------------
module idf_out_queue #(
    parameter int DATA_W = 32,
    parameter int USER_W = idf_pkg::USER_W
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  idf_pkg::res_load_t        ld,
    input  logic [DATA_W-1:0]         ld_data [idf_pkg::MAX_RESULTS],
    input  logic [USER_W-1:0]         ld_user [idf_pkg::MAX_RESULTS],
    output logic                      ld_ready,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [DATA_W-1:0]         m_tdata,
    output logic                      m_tlast,
    output logic [USER_W-1:0]         m_tuser
);
    import idf_pkg::*;

    logic [DATA_W-1:0]    data_reg [MAX_RESULTS];
    logic [USER_W-1:0]    user_reg [MAX_RESULTS];
    logic [RES_CNT_W-1:0] cnt_reg;
    logic [RES_CNT_W-1:0] idx_reg;
    logic                 valid_reg;
    logic                 at_last;

    assign at_last  = (idx_reg == (cnt_reg - RES_CNT_W'(1)));
    assign ld_ready = !valid_reg || (m_tready && at_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            cnt_reg   <= '0;
            idx_reg   <= '0;
        end
        else if (ld.load)
        begin
            valid_reg <= 1'b1;
            cnt_reg   <= ld.cnt;
            idx_reg   <= '0;
        end
        else if (valid_reg && m_tready)
        begin
            if (at_last)
            begin
                valid_reg <= 1'b0;
            end
            else
            begin
                idx_reg <= idx_reg + RES_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld.load)
        begin
            data_reg <= ld_data;
            user_reg <= ld_user;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg[idx_reg];
    assign m_tuser  = user_reg[idx_reg];
    assign m_tlast  = at_last;

endmodule

// ===== sv/image_deglitch_filter.sv =====
// ----------------------------------------------------------------------------
// image_deglitch_filter
// Four-neighbor impulse noise filter on a raster pixel stream.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter on s_t* in raster order, one per transfer. Each pixel of
//   row r >= 1 releases the pixel above it (row r-1); in the last row each
//   input also releases its left neighbor, and the last input of the frame
//   releases itself, so one input yields 0..3 results on m_t*. m_tlast
//   closes the results of one input, m_tuser[1] marks the frame's last pixel.
//   Throughput: one input per cycle while m_tready is high, except in the
//   last row, where the output sets the pace. An input is registered in
//   the compute stage, its results in the output queue. The line store is
//   one dual-read memory of {above, centre} words, read in the accept
//   cycle and written back when the compute stage advances.
//   When m_tready is low, results hold and one more input is taken into the
//   compute stage before s_tready drops. Reset restores 30x30, threshold 1;
//   the line store needs no clearing. Write width or height only while idle:
//   it restarts the frame at row 0, column 0.
// ----------------------------------------------------------------------------
module image_deglitch_filter #(
    parameter int MAX_WIDTH  = idf_pkg::DEF_MAX_WIDTH,
    parameter int PIXEL_BITS = idf_pkg::DEF_PIXEL_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // pixel input
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [((PIXEL_BITS + 7) / 8) * 8-1:0] s_tdata,   // pixel_in
    // results
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // pixel_out, out_row, out_col (zero padded)
    output logic [((PIXEL_BITS + idf_pkg::OUT_ROW_W + idf_pkg::OUT_COL_W + 7) / 8) * 8-1:0]
                                                 m_tdata,
    output logic                                 m_tlast,    // last_of_run
    output logic [idf_pkg::USER_W-1:0]           m_tuser,    // was_replaced, end_of_frame
    // register writes
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [idf_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [idf_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import idf_pkg::*;

    localparam int CW      = $clog2(MAX_WIDTH);
    localparam int MW      = 2 * PIXEL_BITS;
    localparam int OUT_PW  = PIXEL_BITS + OUT_ROW_W + OUT_COL_W;
    localparam int OUT_DW  = ((OUT_PW + 7) / 8) * 8;
    localparam int RST_W   = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;
    localparam logic [CW-1:0]        RST_LAST_COL = CW'(RST_W - 1);
    localparam logic [OUT_ROW_W-1:0] RST_LAST_ROW = OUT_ROW_W'(RESET_HEIGHT - 1);

    // ---------------- configuration ----------------
    logic [CW-1:0]          last_col_reg;
    logic [OUT_ROW_W-1:0]   last_row_reg;
    logic [THR_W-1:0]       thr_reg;
    logic                   restart;
    logic [WIDTH_CFG_W-1:0] width_cfg;

    assign cfg_ready = 1'b1;
    assign width_cfg = cfg_data[WIDTH_CFG_W-1:0];
    assign restart   = cfg_valid && ((cfg_index == REG_IMAGE_WIDTH) ||
                                     (cfg_index == REG_IMAGE_HEIGHT));

    // store last column / last row, saturated to the usable range
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_col_reg <= RST_LAST_COL;
            last_row_reg <= RST_LAST_ROW;
            thr_reg      <= THR_W'(RESET_THRESHOLD);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:
                begin
                    if (width_cfg < WIDTH_CFG_W'(2))
                    begin
                        last_col_reg <= CW'(1);
                    end
                    else if (32'(width_cfg) > MAX_WIDTH)
                    begin
                        last_col_reg <= CW'(MAX_WIDTH - 1);
                    end
                    else
                    begin
                        last_col_reg <= CW'(width_cfg - WIDTH_CFG_W'(1));
                    end
                end
                REG_IMAGE_HEIGHT:
                begin
                    if (cfg_data < CFG_DATA_W'(2))
                    begin
                        last_row_reg <= OUT_ROW_W'(1);
                    end
                    else
                    begin
                        last_row_reg <= OUT_ROW_W'(cfg_data - CFG_DATA_W'(1));
                    end
                end
                REG_GLITCH_THRESHOLD:
                begin
                    thr_reg <= cfg_data[THR_W-1:0];
                end
                default:
                begin
                    thr_reg <= thr_reg;
                end
            endcase
        end
    end

    // ---------------- position counters (accept stage) ----------------
    logic                 s_accept;
    logic [CW-1:0]        col_reg;
    logic [CW-1:0]        col_next;
    logic [OUT_ROW_W-1:0] row_reg;
    logic [OUT_ROW_W-1:0] row_next;

    assign s_accept = s_tvalid && s_tready;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (restart)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (s_accept)
        begin
            if (col_reg == last_col_reg)
            begin
                col_next = '0;
                row_next = (row_reg == last_row_reg) ? '0 : row_reg + OUT_ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ---------------- compute stage registers ----------------
    logic                  s1_valid_reg;
    logic [PIXEL_BITS-1:0] s1_pix_reg;
    logic [CW-1:0]         s1_col_reg;
    logic [OUT_ROW_W-1:0]  s1_row_reg;
    pos_flags_t            s1_flags_reg;
    logic                  s1_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // capture the pixel and precompute its border flags
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s1_pix_reg            <= s_tdata[PIXEL_BITS-1:0];
            s1_col_reg            <= col_reg;
            s1_row_reg            <= row_reg;
            s1_flags_reg.has_out  <= (row_reg != '0);
            s1_flags_reg.above_ok <= (row_reg > OUT_ROW_W'(1));
            s1_flags_reg.left_ok  <= (col_reg != '0);
            s1_flags_reg.left2_ok <= (col_reg > CW'(1));
            s1_flags_reg.right_ok <= (col_reg != last_col_reg);
            s1_flags_reg.last_row <= (row_reg == last_row_reg);
            s1_flags_reg.last_col <= (col_reg == last_col_reg);
        end
    end

    // ---------------- line store ----------------
    logic [MW-1:0]         mem_rd_a;
    logic [MW-1:0]         mem_rd_b;
    logic [PIXEL_BITS-1:0] above_old;
    logic [PIXEL_BITS-1:0] centre_old;
    logic [PIXEL_BITS-1:0] centre_right;

    // word layout: upper half = row above, lower half = centre row
    idf_line_mem #(
        .DEPTH  (MAX_WIDTH),
        .DATA_W (MW)
    ) u_line_mem (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (s_accept),
        .rd_addr_a (col_reg),
        .rd_addr_b (col_reg + CW'(1)),
        .rd_data_a (mem_rd_a),
        .rd_data_b (mem_rd_b),
        .wr_en     (s1_fire),
        .wr_addr   (s1_col_reg),
        .wr_data   ({centre_old, s1_pix_reg})
    );

    assign above_old    = mem_rd_a[MW-1:PIXEL_BITS];
    assign centre_old   = mem_rd_a[PIXEL_BITS-1:0];
    assign centre_right = mem_rd_b[PIXEL_BITS-1:0];

    // ---------------- row history ----------------
    // prev: old centre value one column left (now the row above there)
    // x1, x2: the last two inputs of this row
    logic [PIXEL_BITS-1:0] prev_reg;
    logic [PIXEL_BITS-1:0] x1_reg;
    logic [PIXEL_BITS-1:0] x2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= '0;
            x1_reg   <= '0;
            x2_reg   <= '0;
        end
        else if (restart)
        begin
            prev_reg <= '0;
        end
        else if (s1_fire)
        begin
            prev_reg <= centre_old;
            x1_reg   <= s1_pix_reg;
            x2_reg   <= x1_reg;
        end
    end

    // ---------------- glitch decisions ----------------
    logic [PIXEL_BITS-1:0] nb_up [NB_COUNT];
    logic [PIXEL_BITS-1:0] nb_lf [NB_COUNT];
    logic [PIXEL_BITS-1:0] nb_br [NB_COUNT];
    logic [NB_COUNT-1:0]   en_up;
    logic [NB_COUNT-1:0]   en_lf;
    logic [NB_COUNT-1:0]   en_br;
    logic [PIXEL_BITS-1:0] v_up;
    logic [PIXEL_BITS-1:0] v_lf;
    logic [PIXEL_BITS-1:0] v_br;
    logic                  rep_up;
    logic                  rep_lf;
    logic                  rep_br;

    // pixel above the input: above, below, left, right
    assign nb_up = '{above_old, s1_pix_reg, prev_reg, centre_right};
    assign en_up = {s1_flags_reg.right_ok, s1_flags_reg.left_ok, 1'b1,
                    s1_flags_reg.above_ok};

    // last row, pixel left of the input: above, left, right
    assign nb_lf = '{prev_reg, x2_reg, s1_pix_reg, '0};
    assign en_lf = {1'b0, 1'b1, s1_flags_reg.left2_ok, 1'b1};

    // bottom-right pixel: above, left
    assign nb_br = '{centre_old, x1_reg, '0, '0};
    assign en_br = {1'b0, 1'b0, 1'b1, 1'b1};

    idf_judge #(.PIXEL_BITS(PIXEL_BITS)) u_judge_up (
        .pix      (centre_old),
        .nb       (nb_up),
        .nb_en    (en_up),
        .thr      (thr_reg),
        .pix_out  (v_up),
        .replaced (rep_up)
    );

    idf_judge #(.PIXEL_BITS(PIXEL_BITS)) u_judge_lf (
        .pix      (x1_reg),
        .nb       (nb_lf),
        .nb_en    (en_lf),
        .thr      (thr_reg),
        .pix_out  (v_lf),
        .replaced (rep_lf)
    );

    idf_judge #(.PIXEL_BITS(PIXEL_BITS)) u_judge_br (
        .pix      (s1_pix_reg),
        .nb       (nb_br),
        .nb_en    (en_br),
        .thr      (thr_reg),
        .pix_out  (v_br),
        .replaced (rep_br)
    );

    // ---------------- result group ----------------
    logic [RES_CNT_W-1:0] res_cnt;
    logic [OUT_DW-1:0]    res_data [MAX_RESULTS];
    logic [USER_W-1:0]    res_user [MAX_RESULTS];
    res_load_t            q_ld;
    logic                 q_ready;

    always_comb
    begin
        if (!s1_flags_reg.has_out)
        begin
            res_cnt = RES_CNT_W'(0);
        end
        else if (!s1_flags_reg.last_row || !s1_flags_reg.left_ok)
        begin
            res_cnt = RES_CNT_W'(1);
        end
        else if (!s1_flags_reg.last_col)
        begin
            res_cnt = RES_CNT_W'(2);
        end
        else
        begin
            res_cnt = RES_CNT_W'(3);
        end
    end

    assign res_data[0] = OUT_DW'({OUT_COL_W'(s1_col_reg), s1_row_reg - OUT_ROW_W'(1), v_up});
    assign res_data[1] = OUT_DW'({OUT_COL_W'(s1_col_reg - CW'(1)), s1_row_reg, v_lf});
    assign res_data[2] = OUT_DW'({OUT_COL_W'(s1_col_reg), s1_row_reg, v_br});
    assign res_user[0] = {1'b0, rep_up};
    assign res_user[1] = {1'b0, rep_lf};
    assign res_user[2] = {1'b1, rep_br};

    // advance the compute stage; an input with no result only writes back
    assign s1_fire   = s1_valid_reg && ((res_cnt == '0) || q_ready);
    assign q_ld.load = s1_fire && (res_cnt != '0);
    assign q_ld.cnt  = res_cnt;
    assign s_tready  = !s1_valid_reg || s1_fire;

    idf_out_queue #(
        .DATA_W (OUT_DW),
        .USER_W (USER_W)
    ) u_out_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .ld       (q_ld),
        .ld_data  (res_data),
        .ld_user  (res_user),
        .ld_ready (q_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // ---------------- assertions ----------------
    a_pos_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (col_reg <= last_col_reg) && (row_reg <= last_row_reg))
        else $error("position counter beyond frame size");

    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_fire |=> s1_valid_reg && $stable(s1_col_reg)
                                     && $stable(s1_pix_reg))
        else $error("compute stage lost a stalled pixel");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        q_ld.load |-> q_ready)
        else $error("result group loaded over pending results");

    a_eof_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[USER_EOF] |-> m_tlast)
        else $error("frame end not on the last result of its input");

endmodule
